/* hw/rtl/teleop_velocity_shaper_core_defines.svh */
// ----------------------------------------------------------------------------
// teleop velocity shaper assertion macros
// shared assertion forms used by the shaper rtl
// ----------------------------------------------------------------------------
`ifndef TELEOP_VELOCITY_SHAPER_CORE_DEFINES_SVH
`define TELEOP_VELOCITY_SHAPER_CORE_DEFINES_SVH

// same-cycle implication
`define TVS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TVS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/tvs_pkg.sv */
// ----------------------------------------------------------------------------
// tvs_pkg
// types and constants shared by the velocity shaper core and its divide unit
// ----------------------------------------------------------------------------
package tvs_pkg;

	// config register indexes
	localparam logic [2:0] REG_MAX_FWD_NORMAL  = 3'd0;
	localparam logic [2:0] REG_MAX_SIDE_NORMAL = 3'd1;
	localparam logic [2:0] REG_MAX_TURN_NORMAL = 3'd2;
	localparam logic [2:0] REG_MAX_FWD_RUN     = 3'd3;
	localparam logic [2:0] REG_MAX_SIDE_RUN    = 3'd4;
	localparam logic [2:0] REG_MAX_TURN_RUN    = 3'd5;
	localparam logic [2:0] REG_ACCEL_TRANS     = 3'd6;
	localparam logic [2:0] REG_ACCEL_ROT       = 3'd7;

	localparam logic [5:0]  DIV_STEPS   = 6'd48;
	localparam logic [5:0]  ROOT_STEPS  = 6'd25;
	// ceil(2^45 / 15625): exact floor divide by 15625 for 31 bit dividends
	localparam logic [31:0] RECIP_15625 = 32'd2251799814;
	localparam logic [17:0] VEL_CAP     = 18'd131072;

	typedef struct packed {
		logic        start;
		logic        sqrt_mode;
		logic [49:0] num;
		logic [27:0] den;
		logic [5:0]  steps;
	} iter_req_t;

	typedef struct packed {
		logic        busy;
		logic [47:0] quot;
	} iter_rsp_t;

endpackage

/* hw/rtl/tvs_iter.sv */
// ----------------------------------------------------------------------------
// tvs_iter
// bit-serial restoring divider and digit-by-digit square root on one subtractor
// ----------------------------------------------------------------------------
module tvs_iter (
	input  logic              clk,
	input  logic              arst_n,
	input  tvs_pkg::iter_req_t req,
	output tvs_pkg::iter_rsp_t rsp
);

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic        sqrt_q;
	logic [49:0] num_q;
	logic [27:0] den_q;
	logic [27:0] rem_q;
	logic [47:0] quot_q;

	logic [29:0] cand;
	logic [29:0] sub;
	logic [29:0] diff;
	logic        ge;

	always_comb begin
		if (sqrt_q) begin
			cand = {rem_q, num_q[49:48]};
			sub  = {1'b0, quot_q[26:0], 2'b01};
		end else begin
			cand = {1'b0, rem_q, num_q[49]};
			sub  = {2'b00, den_q};
		end
		diff = cand - sub;
		ge   = (cand >= sub);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= req.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			sqrt_q <= req.sqrt_mode;
			num_q  <= req.num;
			den_q  <= req.den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[27:0] : cand[27:0];
			quot_q <= {quot_q[46:0], ge};
			num_q  <= sqrt_q ? {num_q[47:0], 2'b00} : {num_q[48:0], 1'b0};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.quot = quot_q;

endmodule

/* hw/rtl/teleop_velocity_shaper_core.sv */
// ----------------------------------------------------------------------------
// teleop_velocity_shaper_core
// joystick sample to velocity command with scaling, clamping and
// acceleration limiting through one shared multiplier and a serial divide unit
// ----------------------------------------------------------------------------
// channel   dir  signals                 item
// s_axis    in   s_tvalid/tready/tdata   one joystick sample
// m_axis    out  m_tvalid/tready/tdata   one velocity command
// cfg       in   cfg_we/addr/wdata       one register write, no wait
//
// sample without deadman: goes from accept straight to the finish step
// deadman sample at or past the timeout: scales the three axes, then finishes
// deadman sample within the timeout: also derives the step limits; a limited
//   planar step adds a 25 step root and two 48 step divides on the serial unit
// s_tready is high only in idle; a full output register stalls the finish step
// arst_n clears control, config to defaults and all history to zero
// ----------------------------------------------------------------------------
`include "teleop_velocity_shaper_core_defines.svh"

module teleop_velocity_shaper_core #(
	parameter int unsigned ACCEL_TIMEOUT_US = 250000
) (
	input  logic        clk,
	input  logic        arst_n,
	// deadman[0] run[1] send_goal[2] cancel_goal[3] dpad[7:4] goal_stored[8]
	// axes_present[11:9] axis_fwd[27:12] axis_side[43:28] axis_turn[59:44]
	// time_now[91:60] zero[95:92]
	input  logic [95:0] s_tdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// cmd_fwd[15:0] cmd_side[31:16] cmd_turn[47:32] cmd_active[48]
	// send_goal[49] cancel_goal[50] dpad_events[54:51] zero[55]
	output logic [55:0] m_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [23:0] cfg_wdata
);

	typedef enum logic [24:0] {
		S_IDLE   = 25'd1 << 0,
		S_MF     = 25'd1 << 1,
		S_MS     = 25'd1 << 2,
		S_MT     = 25'd1 << 3,
		S_RQ     = 25'd1 << 4,
		S_VT_MUL = 25'd1 << 5,
		S_VT_REC = 25'd1 << 6,
		S_VT_CAP = 25'd1 << 7,
		S_VR_MUL = 25'd1 << 8,
		S_VR_REC = 25'd1 << 9,
		S_VR_CAP = 25'd1 << 10,
		S_SQX    = 25'd1 << 11,
		S_SQY    = 25'd1 << 12,
		S_SQV    = 25'd1 << 13,
		S_CMP    = 25'd1 << 14,
		S_RT_GO  = 25'd1 << 15,
		S_RT_W   = 25'd1 << 16,
		S_FX_MUL = 25'd1 << 17,
		S_FX_GO  = 25'd1 << 18,
		S_FX_W   = 25'd1 << 19,
		S_FY_MUL = 25'd1 << 20,
		S_FY_GO  = 25'd1 << 21,
		S_FY_W   = 25'd1 << 22,
		S_TURN   = 25'd1 << 23,
		S_FIN    = 25'd1 << 24
	} state_t;

	state_t state_q, state_d;

	// config
	logic [14:0] mfn_q, msn_q, mtn_q, mfr_q, msr_q, mtr_q;
	logic [23:0] acc_t_q, acc_r_q;

	// history
	logic [31:0] last_q;
	logic [15:0] pf_q, ps_q, pt_q;
	logic [15:0] hf_q, hs_q, ht_q;

	// sample latched at accept
	logic        dead_q, run_q, send_q, cancel_q, goal_q;
	logic [3:0]  dpad_q;
	logic [2:0]  pres_q;
	logic [15:0] af_q, as_q, at_q;
	logic [31:0] now_q, dt_q;

	// working registers
	logic [63:0] p_q;
	logic [15:0] rf_q, rs_q, rt_q;
	logic [17:0] vt_q, vr_q;
	logic [33:0] d2_q;
	logic [24:0] m_q;

	// output register
	logic        m_tvalid_q;
	logic [15:0] o_fwd_q, o_side_q, o_turn_q;
	logic        o_act_q, o_send_q, o_cancel_q;
	logic [3:0]  o_dpad_q;

	logic        accept, fin_load, timeout;
	logic [14:0] max_f, max_s, max_t;
	logic [16:0] dx, dy, dw;
	logic [16:0] dxa, dya;
	logic [15:0] dxm, dym;
	logic [16:0] dwm;
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	logic [47:0] rnum;

	tvs_pkg::iter_req_t it_req;
	tvs_pkg::iter_rsp_t it_rsp;

	function automatic logic [15:0] mag16(input logic [15:0] v);
		return v[15] ? (~v + 16'd1) : v;
	endfunction

	function automatic logic [16:0] mag17(input logic [16:0] v);
		return v[16] ? (~v + 17'd1) : v;
	endfunction

	function automatic logic [16:0] sub17(input logic [15:0] a, input logic [15:0] b);
		return {a[15], a} - {b[15], b};
	endfunction

	// round half away from zero of |axis|*max/16384, clamp, restore sign, zero if absent
	function automatic logic [15:0] scale_req(input logic [47:0] p, input logic neg,
			input logic pres, input logic [14:0] maxv);
		logic [31:0] rnd;
		logic [17:0] q;
		logic [15:0] r;
		rnd = p[31:0] + 32'd8192;
		q   = rnd[31:14];
		if (q > {3'b000, maxv}) begin
			q = {3'b000, maxv};
		end
		r = q[15:0];
		if (neg) begin
			r = ~r + 16'd1;
		end
		if (!pres) begin
			r = '0;
		end
		return r;
	endfunction

	// prev +/- step, saturated to 16 bits
	function automatic logic [15:0] step_sat(input logic [15:0] prev, input logic neg,
			input logic [18:0] q);
		logic [19:0] ext;
		logic [19:0] s;
		logic [15:0] r;
		ext = {{4{prev[15]}}, prev};
		s   = neg ? (ext - {1'b0, q}) : (ext + {1'b0, q});
		if (!s[19] && (s[18:15] != 4'h0)) begin
			r = 16'h7FFF;
		end else if (s[19] && (s[18:15] != 4'hF)) begin
			r = 16'h8000;
		end else begin
			r = s[15:0];
		end
		return r;
	endfunction

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign fin_load = (state_q == S_FIN) && (!m_tvalid_q || m_tready);
	assign timeout  = (dt_q >= 32'(ACCEL_TIMEOUT_US));

	assign max_f = run_q ? mfr_q : mfn_q;
	assign max_s = run_q ? msr_q : msn_q;
	assign max_t = run_q ? mtr_q : mtn_q;

	// request minus previous, 17 bit signed
	assign dx  = sub17(rf_q, pf_q);
	assign dy  = sub17(rs_q, ps_q);
	assign dw  = sub17(rt_q, pt_q);
	assign dxa = mag17(dx);
	assign dya = mag17(dy);
	assign dxm = dxa[15:0];
	assign dym = dya[15:0];
	assign dwm = mag17(dw);

	// rounded divide numerator: |d|*vt*256 + m/2
	assign rnum = {p_q[39:0], 8'h00} + {24'h000000, m_q[24:1]};

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MF: begin
				mul_a = {16'h0000, mag16(af_q)};
				mul_b = {17'h00000, max_f};
			end
			S_MS: begin
				mul_a = {16'h0000, mag16(as_q)};
				mul_b = {17'h00000, max_s};
			end
			S_MT: begin
				mul_a = {16'h0000, mag16(at_q)};
				mul_b = {17'h00000, max_t};
			end
			S_VT_MUL: begin
				mul_a = {8'h00, acc_t_q};
				mul_b = {8'h00, dt_q[23:0]};
			end
			S_VR_MUL: begin
				mul_a = {8'h00, acc_r_q};
				mul_b = {8'h00, dt_q[23:0]};
			end
			// divide by one million: drop 6 bits, then multiply by 2^45 / 15625;
			// a product of 2^37 or more is past the cap, so it saturates
			S_VT_REC, S_VR_REC: begin
				mul_a = (p_q[63:37] != '0) ? 32'h7FFF_FFFF : {1'b0, p_q[36:6]};
				mul_b = tvs_pkg::RECIP_15625;
			end
			S_SQX: begin
				mul_a = {16'h0000, dxm};
				mul_b = {16'h0000, dxm};
			end
			S_SQY: begin
				mul_a = {16'h0000, dym};
				mul_b = {16'h0000, dym};
			end
			S_SQV: begin
				mul_a = {14'h0000, vt_q};
				mul_b = {14'h0000, vt_q};
			end
			S_FX_MUL: begin
				mul_a = {16'h0000, dxm};
				mul_b = {14'h0000, vt_q};
			end
			S_FY_MUL: begin
				mul_a = {16'h0000, dym};
				mul_b = {14'h0000, vt_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// divide / root unit requests
	always_comb begin
		it_req = '0;
		case (state_q)
			S_RT_GO: begin
				it_req.start     = 1'b1;
				it_req.sqrt_mode = 1'b1;
				it_req.num       = {d2_q, 16'h0000};
				it_req.steps     = tvs_pkg::ROOT_STEPS;
			end
			S_FX_GO, S_FY_GO: begin
				it_req.start = 1'b1;
				it_req.num   = {rnum, 2'b00};
				it_req.den   = {3'b000, m_q};
				it_req.steps = tvs_pkg::DIV_STEPS;
			end
			default: begin
				it_req = '0;
			end
		endcase
	end

	tvs_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (it_req),
		.rsp    (it_rsp)
	);

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (accept) begin
				state_d = s_tdata[0] ? S_MF : S_FIN;
			end
			S_MF:     state_d = S_MS;
			S_MS:     state_d = S_MT;
			S_MT:     state_d = S_RQ;
			S_RQ:     state_d = timeout ? S_FIN : S_VT_MUL;
			S_VT_MUL: state_d = S_VT_REC;
			S_VT_REC: state_d = S_VT_CAP;
			S_VT_CAP: state_d = S_VR_MUL;
			S_VR_MUL: state_d = S_VR_REC;
			S_VR_REC: state_d = S_VR_CAP;
			S_VR_CAP: state_d = S_SQX;
			S_SQX:    state_d = S_SQY;
			S_SQY:    state_d = S_SQV;
			S_SQV:    state_d = S_CMP;
			// p_q holds vt squared here
			S_CMP:    state_d = ({30'h00000000, d2_q} > p_q) ? S_RT_GO : S_TURN;
			S_RT_GO:  state_d = S_RT_W;
			S_RT_W:   if (!it_rsp.busy) begin
				state_d = S_FX_MUL;
			end
			S_FX_MUL: state_d = S_FX_GO;
			S_FX_GO:  state_d = S_FX_W;
			S_FX_W:   if (!it_rsp.busy) begin
				state_d = S_FY_MUL;
			end
			S_FY_MUL: state_d = S_FY_GO;
			S_FY_GO:  state_d = S_FY_W;
			S_FY_W:   if (!it_rsp.busy) begin
				state_d = S_TURN;
			end
			S_TURN:   state_d = S_FIN;
			S_FIN:    if (fin_load) begin
				state_d = S_IDLE;
			end
			default:  state_d = S_IDLE;
		endcase
	end

	// control, config and history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
			mfn_q      <= 15'd600;
			msn_q      <= 15'd600;
			mtn_q      <= 15'd800;
			mfr_q      <= 15'd600;
			msr_q      <= 15'd600;
			mtr_q      <= 15'd800;
			acc_t_q    <= 24'd100000;
			acc_r_q    <= 24'd100000;
			last_q     <= '0;
			pf_q       <= '0;
			ps_q       <= '0;
			pt_q       <= '0;
			hf_q       <= '0;
			hs_q       <= '0;
			ht_q       <= '0;
		end else begin
			state_q <= state_d;
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (fin_load) begin
				m_tvalid_q <= 1'b1;
				if (dead_q) begin
					last_q <= now_q;
					hf_q   <= rf_q;
					hs_q   <= rs_q;
					ht_q   <= rt_q;
					// a gap at or past the timeout restarts limiting from rest
					pf_q   <= timeout ? 16'h0000 : rf_q;
					ps_q   <= timeout ? 16'h0000 : rs_q;
					pt_q   <= timeout ? 16'h0000 : rt_q;
				end
			end
			if (cfg_we) begin
				case (cfg_addr)
					tvs_pkg::REG_MAX_FWD_NORMAL:  mfn_q   <= cfg_wdata[14:0];
					tvs_pkg::REG_MAX_SIDE_NORMAL: msn_q   <= cfg_wdata[14:0];
					tvs_pkg::REG_MAX_TURN_NORMAL: mtn_q   <= cfg_wdata[14:0];
					tvs_pkg::REG_MAX_FWD_RUN:     mfr_q   <= cfg_wdata[14:0];
					tvs_pkg::REG_MAX_SIDE_RUN:    msr_q   <= cfg_wdata[14:0];
					tvs_pkg::REG_MAX_TURN_RUN:    mtr_q   <= cfg_wdata[14:0];
					tvs_pkg::REG_ACCEL_TRANS:     acc_t_q <= cfg_wdata;
					tvs_pkg::REG_ACCEL_ROT:       acc_r_q <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		p_q <= prod;
		case (state_q)
			S_IDLE: if (accept) begin
				dead_q   <= s_tdata[0];
				run_q    <= s_tdata[1];
				send_q   <= s_tdata[2];
				cancel_q <= s_tdata[3];
				dpad_q   <= s_tdata[7:4];
				goal_q   <= s_tdata[8];
				pres_q   <= s_tdata[11:9];
				af_q     <= s_tdata[27:12];
				as_q     <= s_tdata[43:28];
				at_q     <= s_tdata[59:44];
				now_q    <= s_tdata[91:60];
				dt_q     <= s_tdata[91:60] - last_q;
			end
			S_MS: rf_q <= scale_req(p_q[47:0], af_q[15], pres_q[0], max_f);
			S_MT: rs_q <= scale_req(p_q[47:0], as_q[15], pres_q[1], max_s);
			S_RQ: rt_q <= scale_req(p_q[47:0], at_q[15], pres_q[2], max_t);
			// quotient sits in bits 62:45 of the reciprocal product
			S_VT_CAP: vt_q <= (p_q[62:45] > tvs_pkg::VEL_CAP) ?
				tvs_pkg::VEL_CAP : p_q[62:45];
			S_VR_CAP: vr_q <= (p_q[62:45] > tvs_pkg::VEL_CAP) ?
				tvs_pkg::VEL_CAP : p_q[62:45];
			S_SQY: d2_q <= p_q[33:0];
			S_SQV: d2_q <= d2_q + p_q[33:0];
			S_RT_W: if (!it_rsp.busy) begin
				m_q <= it_rsp.quot[24:0];
			end
			// quotient stays within vt + 1, direction kept by the sign of d
			S_FX_W: if (!it_rsp.busy) begin
				rf_q <= step_sat(pf_q, dx[16], it_rsp.quot[18:0]);
			end
			S_FY_W: if (!it_rsp.busy) begin
				rs_q <= step_sat(ps_q, dy[16], it_rsp.quot[18:0]);
			end
			S_TURN: if ({1'b0, dwm} > vr_q) begin
				rt_q <= step_sat(pt_q, dw[16], {1'b0, vr_q});
			end
			default: ;
		endcase
		if (fin_load) begin
			o_fwd_q    <= dead_q ? rf_q : hf_q;
			o_side_q   <= dead_q ? rs_q : hs_q;
			o_turn_q   <= dead_q ? rt_q : ht_q;
			o_act_q    <= dead_q;
			o_send_q   <= dead_q && goal_q && send_q;
			o_cancel_q <= dead_q && cancel_q;
			o_dpad_q   <= dpad_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, o_dpad_q, o_cancel_q, o_send_q, o_act_q,
		o_turn_q, o_side_q, o_fwd_q};

	`TVS_ASSERT_NOW(a_idle_unit_free, s_tready, !it_rsp.busy, "divide unit busy in idle")
	`TVS_ASSERT_NEXT(a_accept_leaves_idle, accept, state_q != S_IDLE, "accept did not start work")
	`TVS_ASSERT_NEXT(a_fin_sets_valid, fin_load, m_tvalid_q, "finished item not presented")
	`TVS_ASSERT_NOW(a_vt_capped, state_q == S_FX_MUL, vt_q <= tvs_pkg::VEL_CAP,
		"translational step above cap")

endmodule
